>>> rtl/stt_pkg.sv
// stt_pkg: shared types and constants for the source text tokenizer
// no dependencies
package stt_pkg;

    localparam int LINE_W = 16;
    localparam int KIND_W = 6;
    localparam int NUM_KW = 12;
    localparam int KW_LEN_W = 4;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_OPER    = 4'd1,
        M_COMMENT = 4'd2,
        M_INT     = 4'd3,
        M_DOT     = 4'd4,
        M_FRAC    = 4'd5,
        M_STR     = 4'd6,
        M_WORD    = 4'd7
    } mode_t;

    localparam logic [KIND_W-1:0] T_LPAREN     = 6'd0;
    localparam logic [KIND_W-1:0] T_RPAREN     = 6'd1;
    localparam logic [KIND_W-1:0] T_LBRACE     = 6'd2;
    localparam logic [KIND_W-1:0] T_RBRACE     = 6'd3;
    localparam logic [KIND_W-1:0] T_COMMA      = 6'd4;
    localparam logic [KIND_W-1:0] T_DOT        = 6'd5;
    localparam logic [KIND_W-1:0] T_MINUS      = 6'd6;
    localparam logic [KIND_W-1:0] T_PLUS       = 6'd7;
    localparam logic [KIND_W-1:0] T_SEMI       = 6'd8;
    localparam logic [KIND_W-1:0] T_STAR       = 6'd9;
    localparam logic [KIND_W-1:0] T_BANG       = 6'd10;
    localparam logic [KIND_W-1:0] T_BANG_EQ    = 6'd11;
    localparam logic [KIND_W-1:0] T_ASSIGN     = 6'd12;
    localparam logic [KIND_W-1:0] T_EQ_EQ      = 6'd13;
    localparam logic [KIND_W-1:0] T_LESS       = 6'd14;
    localparam logic [KIND_W-1:0] T_LESS_EQ    = 6'd15;
    localparam logic [KIND_W-1:0] T_GREATER    = 6'd16;
    localparam logic [KIND_W-1:0] T_GREATER_EQ = 6'd17;
    localparam logic [KIND_W-1:0] T_SLASH      = 6'd18;
    localparam logic [KIND_W-1:0] T_AMP        = 6'd19;
    localparam logic [KIND_W-1:0] T_AMP_AMP    = 6'd20;
    localparam logic [KIND_W-1:0] T_PIPE       = 6'd21;
    localparam logic [KIND_W-1:0] T_PIPE_PIPE  = 6'd22;
    localparam logic [KIND_W-1:0] T_NUM        = 6'd23;
    localparam logic [KIND_W-1:0] T_STR        = 6'd24;
    localparam logic [KIND_W-1:0] T_IDENT      = 6'd25;
    localparam logic [KIND_W-1:0] T_KW0        = 6'd26;
    localparam logic [KIND_W-1:0] T_END        = 6'd38;
    localparam logic [KIND_W-1:0] T_ERR_BYTE   = 6'd39;
    localparam logic [KIND_W-1:0] T_ERR_STR    = 6'd40;

    localparam logic [7:0] C_LF = 8'h0a;
    localparam logic [7:0] C_CR = 8'h0d;
    localparam logic [7:0] C_TAB = 8'h09;

    // keyword bytes, first byte in bits [7:0]
    function automatic logic [63:0] kw_text(input logic [3:0] i);
        case (i)
            4'd0:    kw_text = 64'h0000_7463_7572_7473;
            4'd1:    kw_text = 64'h0000_0000_6d75_6e65;
            4'd2:    kw_text = 64'h0000_0000_0072_6f66;
            4'd3:    kw_text = 64'h0000_0065_6c69_6877;
            4'd4:    kw_text = 64'h0000_0000_0000_6669;
            4'd5:    kw_text = 64'h0000_0000_0000_6e66;
            4'd6:    kw_text = 64'h0000_0000_6575_7274;
            4'd7:    kw_text = 64'h0000_0065_736c_6166;
            4'd8:    kw_text = 64'h0000_6e72_7574_6572;
            4'd9:    kw_text = 64'h0000_0068_6374_616d;
            4'd10:   kw_text = 64'h0000_0000_0064_6f6d;
            4'd11:   kw_text = 64'h0000_0000_7369_6874;
            default: kw_text = 64'h0;
        endcase
    endfunction

    function automatic logic [KW_LEN_W-1:0] kw_len(input logic [3:0] i);
        case (i)
            4'd0, 4'd8:                kw_len = 4'd6;
            4'd3, 4'd7, 4'd9:          kw_len = 4'd5;
            4'd1, 4'd6, 4'd11:         kw_len = 4'd4;
            4'd2, 4'd10:               kw_len = 4'd3;
            4'd4, 4'd5:                kw_len = 4'd2;
            default:                   kw_len = 4'd0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f);
    endfunction

endpackage

>>> rtl/stt_if.sv
// stt_if: valid/ready channel interfaces for the tokenizer
// no dependencies
interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_byte;
    modport source (output valid, output ch, output last_byte, input ready);
    modport sink (input valid, input ch, input last_byte, output ready);
endinterface

interface stt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_line;
    modport source (output valid, output first_line, input ready);
    modport sink (input valid, input first_line, output ready);
endinterface

interface stt_tok_if #(parameter int POS_WIDTH = 16);
    logic                 valid;
    logic                 ready;
    logic [5:0]           token_kind;
    logic [POS_WIDTH-1:0] start_pos;
    logic [POS_WIDTH-1:0] lexeme_len;
    logic [15:0]          line;
    logic                 last_of_run;
    modport source (output valid, output token_kind, output start_pos, output lexeme_len,
        output line, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_pos, input lexeme_len,
        input line, input last_of_run, output ready);
endinterface

>>> rtl/source_text_tokenizer.sv
// source_text_tokenizer: top level, scanner front, token queue and output stage
// depends on stt_pkg, stt_if, stt_front, stt_queue, stt_back
//
// usage
//   src: one source byte per beat (ch, last_byte); last_byte ends a text
//   tok: tokens (token_kind, start_pos, lexeme_len, line, last_of_run)
//   cfg: first_line, written while idle; reset value 1
// a byte is taken every cycle while the token queue has room for four tokens;
// a byte can yield up to four tokens, which leave one per cycle, so a run of
// token-heavy bytes slows intake to the output rate of one token a cycle
// a token closed by a byte is written to the queue, then loaded into the output
// register, and from there it drives tok
// reset clears the scan state, the queue pointers and the output valid bit; line count
// starts at first_line and the end token after last_byte restarts the scan
// when tok stalls, the queue fills and src ready drops; nothing is lost
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int POS_WIDTH = 16,
    parameter int MAX_KEYWORD_LEN = 6
)
(
    input  logic clk,
    input  logic rst_n,
    stt_byte_if.sink src,
    stt_cfg_if.sink cfg,
    stt_tok_if.source tok
);

    localparam int TOK_W = 6 + 2 * POS_WIDTH + 16 + 1;

    logic               q_room, q_push, q_valid, q_pop;
    logic [2:0]         q_count;
    logic [4*TOK_W-1:0] q_wdata;
    logic [TOK_W-1:0]   q_rdata, out_data;

    assign cfg.ready = 1'b1;

    stt_front #(.POS_WIDTH(POS_WIDTH), .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .TOK_W(TOK_W))
        u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(src.valid), .in_ready(src.ready), .ch(src.ch), .last_byte(src.last_byte),
        .cfg_valid(cfg.valid), .cfg_data(cfg.first_line),
        .q_room(q_room), .q_push(q_push), .q_count(q_count), .q_data(q_wdata)
    );

    stt_queue #(.TOK_W(TOK_W)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_count(q_count), .push_data(q_wdata), .room(q_room),
        .pop_valid(q_valid), .pop(q_pop), .pop_data(q_rdata)
    );

    stt_back #(.POS_WIDTH(POS_WIDTH), .TOK_W(TOK_W)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_rdata),
        .valid(tok.valid), .ready(tok.ready), .data(out_data)
    );

    assign {tok.token_kind, tok.start_pos, tok.lexeme_len, tok.line, tok.last_of_run}
        = out_data;

endmodule

>>> rtl/stt_front.sv
// stt_front: scan state machine, turns each byte into up to four tokens
// depends on stt_pkg; feeds stt_queue
module stt_front
    import stt_pkg::*;
#(
    parameter int POS_WIDTH = 16,
    parameter int MAX_KEYWORD_LEN = 6,
    parameter int TOK_W = 6 + 2 * POS_WIDTH + 16 + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           ch,
    input  logic                 last_byte,
    input  logic                 cfg_valid,
    input  logic [15:0]          cfg_data,
    input  logic                 q_room,
    output logic                 q_push,
    output logic [2:0]           q_count,
    output logic [4*TOK_W-1:0]   q_data
);

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam int WP_W = 8 * MAX_KEYWORD_LEN;
    localparam int WL_W = $clog2(MAX_KEYWORD_LEN + 2);

    mode_t                mode_reg, mode_next;
    logic [POS_WIDTH-1:0] tstart_reg, tstart_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [15:0]          line_reg, line_next;
    logic [15:0]          first_reg;
    logic [WP_W-1:0]      wp_reg, wp_next;
    logic [WL_W-1:0]      wl_reg, wl_next;
    logic [7:0]           pc_reg, pc_next;

    logic                 fire;
    logic [POS_WIDTH-1:0] p, e;
    logic [2:0]           n;
    logic [5:0]           k_arr [4];
    logic [POS_WIDTH-1:0] s_arr [4];
    logic [POS_WIDTH-1:0] l_arr [4];
    logic [15:0]          ln_arr [4];
    logic [5:0]           wkind;
    logic [WP_W-1:0]      wp_upd;
    logic [WL_W-1:0]      wl_upd;
    logic [5:0]           fkind;

    assign fire = in_valid && in_ready;
    assign in_ready = q_room;
    assign p = pos_reg;
    assign e = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : POS_MAX;

    function automatic logic [POS_WIDTH-1:0] span(input logic [POS_WIDTH-1:0] a,
        input logic [POS_WIDTH-1:0] b);
        span = (b >= a) ? b - a : '0;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h21:   single_kind = T_BANG;
            8'h3d:   single_kind = T_ASSIGN;
            8'h3c:   single_kind = T_LESS;
            8'h3e:   single_kind = T_GREATER;
            8'h26:   single_kind = T_AMP;
            8'h7c:   single_kind = T_PIPE;
            default: single_kind = T_SLASH;
        endcase
    endfunction

    // keyword lookup
    always_comb
    begin
        wkind = T_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--)
        begin
            if ((wl_reg <= WL_W'(MAX_KEYWORD_LEN))
                && (32'(wl_reg) == 32'(kw_len(4'(i))))
                && (64'(wp_reg) == kw_text(4'(i))))
                wkind = T_KW0 + 6'(i);
        end
    end

    // word state once this byte is taken
    always_comb
    begin
        if (mode_reg == M_WORD)
        begin
            if (wl_reg < WL_W'(MAX_KEYWORD_LEN))
            begin
                wp_upd = wp_reg | (WP_W'(ch) << (8 * wl_reg));
                wl_upd = wl_reg + 1'b1;
            end
            else
            begin
                wp_upd = wp_reg;
                wl_upd = WL_W'(MAX_KEYWORD_LEN + 1);
            end
        end
        else
        begin
            wp_upd = WP_W'(ch);
            wl_upd = WL_W'(1);
        end
    end

    // keyword check of the flushed word
    always_comb
    begin
        fkind = T_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--)
        begin
            if ((wl_upd <= WL_W'(MAX_KEYWORD_LEN))
                && (32'(wl_upd) == 32'(kw_len(4'(i))))
                && (64'(wp_upd) == kw_text(4'(i))))
                fkind = T_KW0 + 6'(i);
        end
    end

    always_comb
    begin
        logic [15:0] ln;
        logic        idle_go;
        mode_next = mode_reg;
        tstart_next = tstart_reg;
        pos_next = pos_reg;
        line_next = line_reg;
        wp_next = wp_reg;
        wl_next = wl_reg;
        pc_next = pc_reg;
        n = '0;
        idle_go = 1'b0;
        ln = line_reg;
        for (int i = 0; i < 4; i++)
        begin
            k_arr[i] = '0;
            s_arr[i] = '0;
            l_arr[i] = '0;
            ln_arr[i] = '0;
        end
        if (fire)
        begin
            case (mode_reg)
                M_OPER:
                begin
                    if (ch == 8'h3d && (pc_reg == 8'h21 || pc_reg == 8'h3d
                        || pc_reg == 8'h3c || pc_reg == 8'h3e))
                    begin
                        k_arr[0] = (pc_reg == 8'h21) ? T_BANG_EQ :
                            (pc_reg == 8'h3d) ? T_EQ_EQ :
                            (pc_reg == 8'h3c) ? T_LESS_EQ : T_GREATER_EQ;
                        s_arr[0] = tstart_reg; l_arr[0] = POS_WIDTH'(2);
                        n = 3'd1; mode_next = M_IDLE;
                    end
                    else if ((ch == 8'h26 && pc_reg == 8'h26) || (ch == 8'h7c && pc_reg == 8'h7c))
                    begin
                        k_arr[0] = (ch == 8'h26) ? T_AMP_AMP : T_PIPE_PIPE;
                        s_arr[0] = tstart_reg; l_arr[0] = POS_WIDTH'(2);
                        n = 3'd1; mode_next = M_IDLE;
                    end
                    else if (ch == 8'h2f && pc_reg == 8'h2f)
                        mode_next = M_COMMENT;
                    else
                    begin
                        k_arr[0] = single_kind(pc_reg);
                        s_arr[0] = tstart_reg; l_arr[0] = POS_WIDTH'(1);
                        n = 3'd1; idle_go = 1'b1;
                    end
                end
                M_COMMENT:
                    if (ch == C_LF)
                        idle_go = 1'b1;
                M_INT:
                    if (ch == 8'h2e)
                        mode_next = M_DOT;
                    else if (!is_digit(ch))
                    begin
                        k_arr[0] = T_NUM; s_arr[0] = tstart_reg;
                        l_arr[0] = span(tstart_reg, p); n = 3'd1; idle_go = 1'b1;
                    end
                M_DOT:
                    if (is_digit(ch))
                        mode_next = M_FRAC;
                    else
                    begin
                        k_arr[0] = T_NUM; s_arr[0] = tstart_reg;
                        l_arr[0] = span(tstart_reg, (p != '0) ? p - 1'b1 : '0);
                        k_arr[1] = T_DOT; s_arr[1] = (p != '0) ? p - 1'b1 : '0;
                        l_arr[1] = POS_WIDTH'(1);
                        n = 3'd2; idle_go = 1'b1;
                    end
                M_FRAC:
                    if (!is_digit(ch))
                    begin
                        k_arr[0] = T_NUM; s_arr[0] = tstart_reg;
                        l_arr[0] = span(tstart_reg, p); n = 3'd1; idle_go = 1'b1;
                    end
                M_STR:
                    if (ch == 8'h22)
                    begin
                        k_arr[0] = T_STR; s_arr[0] = tstart_reg;
                        l_arr[0] = span(tstart_reg, p) + 1'b1;
                        n = 3'd1; mode_next = M_IDLE;
                    end
                    else if (ch == C_LF && ln != 16'hffff)
                        ln = ln + 1'b1;
                M_WORD:
                    if (is_alpha(ch) || is_digit(ch))
                    begin
                        wp_next = wp_upd;
                        wl_next = wl_upd;
                    end
                    else
                    begin
                        k_arr[0] = wkind; s_arr[0] = tstart_reg;
                        l_arr[0] = span(tstart_reg, p); n = 3'd1; idle_go = 1'b1;
                    end
                default:
                    idle_go = 1'b1;
            endcase
            for (int i = 0; i < 4; i++)
                ln_arr[i] = ln;
            if (idle_go)
            begin
                mode_next = M_IDLE;
                case (ch)
                    8'h28, 8'h29, 8'h7b, 8'h7d, 8'h2c, 8'h2e, 8'h2d, 8'h2b, 8'h3b, 8'h2a:
                    begin
                        k_arr[n[1:0]] = (ch == 8'h28) ? T_LPAREN : (ch == 8'h29) ? T_RPAREN :
                            (ch == 8'h7b) ? T_LBRACE : (ch == 8'h7d) ? T_RBRACE :
                            (ch == 8'h2c) ? T_COMMA : (ch == 8'h2e) ? T_DOT :
                            (ch == 8'h2d) ? T_MINUS : (ch == 8'h2b) ? T_PLUS :
                            (ch == 8'h3b) ? T_SEMI : T_STAR;
                        s_arr[n[1:0]] = p; l_arr[n[1:0]] = POS_WIDTH'(1);
                        n = n + 1'b1;
                    end
                    8'h21, 8'h3d, 8'h3c, 8'h3e, 8'h26, 8'h7c, 8'h2f:
                    begin
                        mode_next = M_OPER; pc_next = ch; tstart_next = p;
                    end
                    8'h20, C_CR, C_TAB:
                        ;
                    C_LF:
                        if (ln != 16'hffff)
                            ln = ln + 1'b1;
                    8'h22:
                    begin
                        mode_next = M_STR; tstart_next = p;
                    end
                    default:
                        if (is_digit(ch))
                        begin
                            mode_next = M_INT; tstart_next = p;
                        end
                        else if (is_alpha(ch))
                        begin
                            mode_next = M_WORD; tstart_next = p;
                            wp_next = WP_W'(ch); wl_next = WL_W'(1);
                        end
                        else
                        begin
                            k_arr[n[1:0]] = T_ERR_BYTE; s_arr[n[1:0]] = p;
                            l_arr[n[1:0]] = POS_WIDTH'(1); ln_arr[n[1:0]] = ln;
                            n = n + 1'b1;
                        end
                endcase
            end
            line_next = ln;
            pos_next = e;
            if (last_byte)
            begin
                // flush pending lexeme, then the end token
                case (mode_next)
                    M_OPER:
                    begin
                        k_arr[n[1:0]] = single_kind(pc_next); s_arr[n[1:0]] = tstart_next;
                        l_arr[n[1:0]] = POS_WIDTH'(1); ln_arr[n[1:0]] = ln;
                        n = n + 1'b1;
                    end
                    M_INT, M_FRAC:
                    begin
                        k_arr[n[1:0]] = T_NUM; s_arr[n[1:0]] = tstart_next;
                        l_arr[n[1:0]] = span(tstart_next, e); ln_arr[n[1:0]] = ln;
                        n = n + 1'b1;
                    end
                    M_DOT:
                    begin
                        k_arr[n[1:0]] = T_NUM; s_arr[n[1:0]] = tstart_next;
                        l_arr[n[1:0]] = span(tstart_next, e - 1'b1); ln_arr[n[1:0]] = ln;
                        n = n + 1'b1;
                        k_arr[n[1:0]] = T_DOT; s_arr[n[1:0]] = e - 1'b1;
                        l_arr[n[1:0]] = POS_WIDTH'(1); ln_arr[n[1:0]] = ln;
                        n = n + 1'b1;
                    end
                    M_STR:
                    begin
                        k_arr[n[1:0]] = T_ERR_STR; s_arr[n[1:0]] = tstart_next;
                        l_arr[n[1:0]] = span(tstart_next, e); ln_arr[n[1:0]] = ln;
                        n = n + 1'b1;
                    end
                    M_WORD:
                    begin
                        k_arr[n[1:0]] = fkind;
                        s_arr[n[1:0]] = tstart_next;
                        l_arr[n[1:0]] = span(tstart_next, e); ln_arr[n[1:0]] = ln;
                        n = n + 1'b1;
                    end
                    default:
                        ;
                endcase
                k_arr[n[1:0]] = T_END; s_arr[n[1:0]] = e; l_arr[n[1:0]] = '0;
                ln_arr[n[1:0]] = ln;
                n = n + 1'b1;
                mode_next = M_IDLE; tstart_next = '0; pos_next = '0;
                line_next = first_reg; wp_next = '0; wl_next = '0; pc_next = '0;
            end
        end
        else if (cfg_valid && pos_reg == '0 && mode_reg == M_IDLE)
            line_next = cfg_data;
    end

    always_comb
    begin
        q_push = fire && (n != '0);
        q_count = n;
        for (int i = 0; i < 4; i++)
            q_data[i*TOK_W +: TOK_W] = {k_arr[i], s_arr[i], l_arr[i], ln_arr[i],
                (3'(i) == n - 1'b1)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            tstart_reg <= '0;
            pos_reg <= '0;
            line_reg <= 16'd1;
            first_reg <= 16'd1;
            wp_reg <= '0;
            wl_reg <= '0;
            pc_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            tstart_reg <= tstart_next;
            pos_reg <= pos_next;
            line_reg <= line_next;
            wp_reg <= wp_next;
            wl_reg <= wl_next;
            pc_reg <= pc_next;
            if (cfg_valid)
                first_reg <= cfg_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_byte) |=> (pos_reg == '0 && mode_reg == M_IDLE))
        else $error("scan state not restarted after last beat");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_byte) |-> (n != '0))
        else $error("last beat without end token");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_room)
        else $error("push into full queue");

endmodule

>>> rtl/stt_queue.sv
// stt_queue: token queue between scanner and output, takes up to four tokens a beat
// depends on stt_pkg
module stt_queue
    import stt_pkg::*;
#(
    parameter int TOK_W = 49
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [2:0]         push_count,
    input  logic [4*TOK_W-1:0] push_data,
    output logic               room,
    output logic               pop_valid,
    input  logic               pop,
    output logic [TOK_W-1:0]   pop_data
);

    localparam int DEPTH = 8;

    logic [TOK_W-1:0] mem_reg [DEPTH];
    logic [2:0]       rd_reg, wr_reg;
    logic [3:0]       cnt_reg, cnt_next;
    logic             do_pop;

    assign do_pop = pop && pop_valid;
    assign pop_valid = cnt_reg != '0;
    assign pop_data = mem_reg[rd_reg];
    // room for a worst-case beat of four tokens
    assign room = cnt_reg <= 4'd4;

    always_comb
    begin
        cnt_next = cnt_reg + (push ? {1'b0, push_count} : 4'd0) - {3'd0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (3'(i) < push_count)
                    mem_reg[wr_reg + 3'(i)] <= push_data[i*TOK_W +: TOK_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + push_count;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'd8)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!push && do_pop) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count slip");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_count > 3'd4) |-> 1'b0)
        else $error("too many tokens in one beat");

endmodule

>>> rtl/stt_back.sv
// stt_back: output register stage, drives the token channel from the queue
// depends on stt_pkg
module stt_back
    import stt_pkg::*;
#(
    parameter int POS_WIDTH = 16,
    parameter int TOK_W = 6 + 2 * POS_WIDTH + 16 + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic [TOK_W-1:0]     q_data,
    output logic                 valid,
    input  logic                 ready,
    output logic [TOK_W-1:0]     data
);

    logic             vld_reg;
    logic [TOK_W-1:0] data_reg;

    assign q_pop = q_valid && (!vld_reg || ready);
    assign valid = vld_reg;
    assign data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (!vld_reg || ready)
            vld_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !ready) |=> (vld_reg && $stable(data_reg)))
        else $error("held token changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> vld_reg)
        else $error("popped token lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !ready) |-> !q_pop)
        else $error("pop while stalled");

endmodule

>>> tb/stt_scoreboard.sv
// stt_scoreboard: token predictor and expected-token store for the tokenizer bench
// depends on stt_pkg
`timescale 1ns / 1ps
package stt_tb_pkg;
    import stt_pkg::*;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } token_t;

    class token_scoreboard;
        token_t      pending_tokens[$];
        int          errors;
        logic [15:0] first_line;
        mode_t       mode;
        logic [15:0] tok_start;
        logic [15:0] pos;
        logic [15:0] line_cnt;
        logic [47:0] word_bytes;
        int          word_len;
        logic [7:0]  op_char;
        token_t      step_toks[$];

        function new();
            errors = 0;
            first_line = 16'd1;
            restart();
        endfunction

        function void restart();
            mode = M_IDLE;
            tok_start = '0;
            pos = '0;
            line_cnt = first_line;
            word_bytes = '0;
            word_len = 0;
            op_char = '0;
        endfunction

        function void set_first_line(logic [15:0] v);
            first_line = v;
            if (pos == 0 && mode == M_IDLE)
                line_cnt = v;
        endfunction

        function void push(logic [5:0] k, logic [15:0] s, logic [15:0] l);
            token_t t;
            t.kind = k;
            t.start = s;
            t.len = l;
            t.line = line_cnt;
            t.last = 1'b0;
            step_toks.push_back(t);
        endfunction

        function logic [15:0] dist16(logic [15:0] a, logic [15:0] b);
            return (b >= a) ? b - a : 16'd0;
        endfunction

        function void next_line();
            if (line_cnt != 16'hffff)
                line_cnt++;
        endfunction

        function logic [5:0] kw_kind();
            string names[12];
            names = '{"struct", "enum", "for", "while", "if", "fn", "true", "false",
                "return", "match", "mod", "this"};
            if (word_len > 6)
                return T_IDENT;
            for (int i = 0; i < 12; i++)
            begin
                bit same;
                if (names[i].len() != word_len)
                    continue;
                same = 1;
                for (int j = 0; j < word_len; j++)
                    if (word_bytes[8*j +: 8] != names[i][j])
                        same = 0;
                if (same)
                    return T_KW0 + 6'(i);
            end
            return T_IDENT;
        endfunction

        function logic [5:0] op_single(logic [7:0] c);
            case (c)
                "!": return T_BANG;
                "=": return T_ASSIGN;
                "<": return T_LESS;
                ">": return T_GREATER;
                "&": return T_AMP;
                "|": return T_PIPE;
                default: return T_SLASH;
            endcase
        endfunction

        function void from_idle(logic [7:0] c, logic [15:0] p);
            mode = M_IDLE;
            case (c)
                "(": push(T_LPAREN, p, 16'd1);
                ")": push(T_RPAREN, p, 16'd1);
                "{": push(T_LBRACE, p, 16'd1);
                "}": push(T_RBRACE, p, 16'd1);
                ",": push(T_COMMA, p, 16'd1);
                ".": push(T_DOT, p, 16'd1);
                "-": push(T_MINUS, p, 16'd1);
                "+": push(T_PLUS, p, 16'd1);
                ";": push(T_SEMI, p, 16'd1);
                "*": push(T_STAR, p, 16'd1);
                "!", "=", "<", ">", "&", "|", "/":
                begin
                    mode = M_OPER;
                    op_char = c;
                    tok_start = p;
                end
                " ", C_CR, C_TAB: ;
                C_LF: next_line();
                "\"":
                begin
                    mode = M_STR;
                    tok_start = p;
                end
                default:
                    if (is_digit(c))
                    begin
                        mode = M_INT;
                        tok_start = p;
                    end
                    else if (is_alpha(c))
                    begin
                        mode = M_WORD;
                        tok_start = p;
                        word_bytes = {40'd0, c};
                        word_len = 1;
                    end
                    else
                        push(T_ERR_BYTE, p, 16'd1);
            endcase
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            logic [15:0] p, e, dp;
            p = pos;
            e = (p != 16'hffff) ? p + 16'd1 : p;
            dp = (p > 0) ? p - 16'd1 : 16'd0;
            step_toks.delete();
            case (mode)
                M_OPER:
                    if (c == "=" && (op_char inside {"!", "=", "<", ">"}))
                    begin
                        push(op_char == "!" ? T_BANG_EQ : op_char == "=" ? T_EQ_EQ :
                            op_char == "<" ? T_LESS_EQ : T_GREATER_EQ, tok_start, 16'd2);
                        mode = M_IDLE;
                    end
                    else if (c == "&" && op_char == "&")
                    begin
                        push(T_AMP_AMP, tok_start, 16'd2);
                        mode = M_IDLE;
                    end
                    else if (c == "|" && op_char == "|")
                    begin
                        push(T_PIPE_PIPE, tok_start, 16'd2);
                        mode = M_IDLE;
                    end
                    else if (c == "/" && op_char == "/")
                        mode = M_COMMENT;
                    else
                    begin
                        push(op_single(op_char), tok_start, 16'd1);
                        from_idle(c, p);
                    end
                M_COMMENT:
                    if (c == C_LF)
                        from_idle(c, p);
                M_INT:
                    if (c == ".")
                        mode = M_DOT;
                    else if (!is_digit(c))
                    begin
                        push(T_NUM, tok_start, dist16(tok_start, p));
                        from_idle(c, p);
                    end
                M_DOT:
                    if (is_digit(c))
                        mode = M_FRAC;
                    else
                    begin
                        push(T_NUM, tok_start, dist16(tok_start, dp));
                        push(T_DOT, dp, 16'd1);
                        from_idle(c, p);
                    end
                M_FRAC:
                    if (!is_digit(c))
                    begin
                        push(T_NUM, tok_start, dist16(tok_start, p));
                        from_idle(c, p);
                    end
                M_STR:
                    if (c == "\"")
                    begin
                        push(T_STR, tok_start, dist16(tok_start, p) + 16'd1);
                        mode = M_IDLE;
                    end
                    else if (c == C_LF)
                        next_line();
                M_WORD:
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (word_len < 6)
                        begin
                            word_bytes[8*word_len +: 8] = c;
                            word_len++;
                        end
                        else
                            word_len = 7;
                    end
                    else
                    begin
                        push(kw_kind(), tok_start, dist16(tok_start, p));
                        from_idle(c, p);
                    end
                default: from_idle(c, p);
            endcase
            pos = e;
            if (last)
            begin
                logic [15:0] ep;
                ep = (e > 0) ? e - 16'd1 : 16'd0;
                case (mode)
                    M_OPER: push(op_single(op_char), tok_start, 16'd1);
                    M_INT, M_FRAC: push(T_NUM, tok_start, dist16(tok_start, e));
                    M_DOT:
                    begin
                        push(T_NUM, tok_start, dist16(tok_start, ep));
                        push(T_DOT, ep, 16'd1);
                    end
                    M_STR: push(T_ERR_STR, tok_start, dist16(tok_start, e));
                    M_WORD: push(kw_kind(), tok_start, dist16(tok_start, e));
                    default: ;
                endcase
                push(T_END, e, 16'd0);
                restart();
            end
            if (step_toks.size() > 0)
                step_toks[$].last = 1'b1;
            foreach (step_toks[i])
                pending_tokens.push_back(step_toks[i]);
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected token %p", $time, got);
                errors++;
                return;
            end
            want = pending_tokens.pop_front();
            if (got !== want)
            begin
                $display("%0t: token mismatch expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass
endpackage

>>> tb/testbench.sv
// testbench: drives bytes and first_line writes into the tokenizer, checks tokens
// depends on stt_pkg, stt_if, stt_tb_pkg and the tokenizer rtl
`timescale 1ns / 1ps
module testbench;
    import stt_pkg::*;
    import stt_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   gaps_on = 1'b1;
    bit   hold_on = 1'b0;
    int   bytes_sent = 0;
    token_t t_got;
    token_scoreboard tokens_sb = new();

    stt_byte_if src();
    stt_cfg_if  cfg();
    stt_tok_if  tok();

    source_text_tokenizer dut (.clk(clk), .rst_n(rst_n), .src(src), .cfg(cfg), .tok(tok));

    always #1 clk = ~clk;

    initial
    begin
        src.valid = 1'b0;
        src.ch = '0;
        src.last_byte = 1'b0;
        cfg.valid = 1'b0;
        cfg.first_line = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // long receiver hold while bytes keep coming
    initial
    begin
        wait (bytes_sent > 120);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (60) @(posedge clk);
        hold_on = 1'b0;
    end

    // token sink with random stalls and the long hold
    initial
    begin
        int stall;
        stall = 0;
        tok.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_on)
                tok.ready <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                tok.ready <= 1'b0;
            end
            else
            begin
                tok.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 9) == 0)
                    stall = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && tok.valid && tok.ready)
        begin
            t_got.kind = tok.token_kind;
            t_got.start = tok.start_pos;
            t_got.len = tok.lexeme_len;
            t_got.line = tok.line;
            t_got.last = tok.last_of_run;
            tokens_sb.check_token(t_got);
        end

    task automatic send_byte(logic [7:0] c, logic last);
        if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            src.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        src.valid <= 1'b1;
        src.ch <= c;
        src.last_byte <= last;
        do @(posedge clk); while (!src.ready);
        tokens_sb.note_byte(c, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s, bit closed);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], closed && i == s.len() - 1);
    endtask

    task automatic write_first_line(logic [15:0] v);
        src.valid <= 1'b0;
        while (tokens_sb.pending_tokens.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.first_line <= v;
        do @(posedge clk); while (!cfg.ready);
        tokens_sb.set_first_line(v);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        string alphabet;
        alphabet = "(){},.-+;*!=<>&|/ \"_azAZ09.\n\t\015#";
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(8'h30, 8'h39));
            2: return 8'($urandom_range(8'h61, 8'h7a));
            default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
        endcase
    endfunction

    function automatic string pick_piece();
        string pieces[18];
        pieces = '{"struct ", "enum", "for(", "while ", "if{", "fn ", "true;", "false",
            "return ", "match", "mod ", "this.", "12.5 ", "7..", "\"ab\ncd\"", "a_bcdefgh ",
            "// note\n", "x!=y<=z>=w==q&&r||s"};
        return pieces[$urandom_range(0, 17)];
    endfunction

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        // directed: every operator, number forms, strings, errors
        send_text("(){},.-+;*! != = == < <= > >= / & && | || // c\n", 0);
        send_text("3.14 42. x 5", 1);
        write_first_line(16'hffff);
        send_text("\"open\nstr", 1);
        write_first_line(16'd0);
        send_text("\t\015\x01\xff@", 0);
        send_text("<", 1);
        send_text("1.", 1);
        write_first_line(16'd1);
        send_text("ab1", 1);
        // random texts, mostly token-like pieces
        while (bytes_sent < 360)
        begin
            if (bytes_sent > 300)
                gaps_on = 1'b0;
            if ($urandom_range(0, 2) == 0)
                send_byte(pick_byte(), $urandom_range(0, 15) == 0);
            else
                send_text(pick_piece(), 0);
            if ($urandom_range(0, 20) == 0)
            begin
                send_byte(pick_byte(), 1'b1);
                write_first_line(16'($urandom_range(0, 65535)));
            end
        end
        send_byte("a", 1'b1);
        src.valid <= 1'b0;
        while (tokens_sb.pending_tokens.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (tokens_sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #200000;
        $display("FAIL");
        $finish;
    end
endmodule
